/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
    `ASSERT_CLK(lbl, !(expr), msg)
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

/* hdl/tld_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tld_pkg
// Beat types, sequencer codes and control/status bundles for the D' block.
// ---------------------------------------------------------------------------
package tld_pkg;

    localparam int BASE_W     = 3;
    localparam int DPRIME_W   = 17;
    localparam int TOTAL_W    = 17;
    localparam int FRAC_BITS  = 16;
    localparam logic [DPRIME_W-1:0] DPRIME_ONE = 17'h10000;

    typedef struct packed {
        logic [BASE_W-1:0] first_base;
        logic [BASE_W-1:0] second_base;
        logic              last_haplotype;
    } in_t;

    typedef struct packed {
        logic [DPRIME_W-1:0] dprime;
        logic                undefined_flag;
        logic [TOTAL_W-1:0]  haplotype_total;
    } out_t;

    // Multiply sequence, in issue order
    typedef enum logic [2:0] {
        OP_MS1 = 3'd0,  // m * s1
        OP_OBS = 3'd1,  // (m*s1) * s2
        OP_C12 = 3'd2,  // c1 * c2
        OP_EXP = 3'd3,  // (c1*c2) * n
        OP_X   = 3'd4,  // C1 * (c2 or C2)
        OP_Y   = 3'd5,  // c1 * (C2 or c2)
        OP_DEN = 3'd6   // min(x,y) * n
    } mul_op_t;

    typedef enum logic [1:0] {
        RES_UNDEF = 2'd0,
        RES_SAT   = 2'd1,
        RES_QUOT  = 2'd2
    } res_kind_t;

    typedef struct packed {
        logic      count;
        logic      pick;
        logic      mul_load;
        logic      mul_step;
        logic      mul_save;
        mul_op_t   mul_op;
        logic      div_load;
        logic      div_step;
        logic      emit;
        res_kind_t res;
    } cmd_t;

    typedef struct packed {
        logic ok;
        logic step_done;
        logic den_zero;
        logic r_ge_den;
    } status_t;

endpackage

/* hdl/tld_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tld_ctrl
// Sequencer: counting, allele pick, multiply chain, divide, result emit.
// ---------------------------------------------------------------------------
module tld_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last,
    input  tld_pkg::status_t st,
    output tld_pkg::cmd_t    cmd,
    output logic             busy
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PICK  = 9'b000000010,
        ST_MLOAD = 9'b000000100,
        ST_MRUN  = 9'b000001000,
        ST_MSAVE = 9'b000010000,
        ST_DLOAD = 9'b000100000,
        ST_DTEST = 9'b001000000,
        ST_DRUN  = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    tld_pkg::mul_op_t    op_reg, op_next;
    tld_pkg::res_kind_t  res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= tld_pkg::OP_MS1;
            res_reg   <= tld_pkg::RES_UNDEF;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            res_reg   <= res_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        res_next     = res_reg;
        cmd          = '0;
        cmd.mul_op   = op_reg;
        cmd.res      = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.count = 1'b1;
                    if (last)
                        state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                cmd.pick = 1'b1;
                if (st.ok)
                begin
                    op_next    = tld_pkg::OP_MS1;
                    state_next = ST_MLOAD;
                end
                else
                begin
                    res_next   = tld_pkg::RES_UNDEF;
                    state_next = ST_EMIT;
                end
            end
            ST_MLOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_MRUN;
            end
            ST_MRUN:
            begin
                cmd.mul_step = 1'b1;
                if (st.step_done)
                    state_next = ST_MSAVE;
            end
            ST_MSAVE:
            begin
                cmd.mul_save = 1'b1;
                unique case (op_reg)
                    tld_pkg::OP_MS1: op_next = tld_pkg::OP_OBS;
                    tld_pkg::OP_OBS: op_next = tld_pkg::OP_C12;
                    tld_pkg::OP_C12: op_next = tld_pkg::OP_EXP;
                    tld_pkg::OP_EXP: op_next = tld_pkg::OP_X;
                    tld_pkg::OP_X:   op_next = tld_pkg::OP_Y;
                    tld_pkg::OP_Y:   op_next = tld_pkg::OP_DEN;
                    default:         op_next = tld_pkg::OP_MS1;
                endcase
                state_next = (op_reg == tld_pkg::OP_DEN) ? ST_DLOAD : ST_MLOAD;
            end
            ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DTEST;
            end
            ST_DTEST:
            begin
                if (st.den_zero)
                begin
                    res_next   = tld_pkg::RES_UNDEF;
                    state_next = ST_EMIT;
                end
                else if (st.r_ge_den)
                begin
                    res_next   = tld_pkg::RES_SAT;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_DRUN;
            end
            ST_DRUN:
            begin
                cmd.div_step = 1'b1;
                if (st.step_done)
                begin
                    res_next   = tld_pkg::RES_QUOT;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

/* hdl/tld_dpath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tld_dpath
// Base/pair counters, allele pick, shift-add multiplier, restoring divider.
// ---------------------------------------------------------------------------
module tld_dpath
#(
    parameter int MAX_HAPLOTYPES = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tld_pkg::in_t     item,
    input  tld_pkg::cmd_t    cmd,
    output tld_pkg::status_t st,
    output logic             strobe,
    output tld_pkg::out_t    result
);

    localparam int CW      = $clog2(MAX_HAPLOTYPES + 1);
    localparam int PW      = 3 * CW;
    localparam int STEPS_M = (CW > tld_pkg::FRAC_BITS) ? CW : tld_pkg::FRAC_BITS;
    localparam int SW      = $clog2(STEPS_M);

    logic [3:0][CW-1:0]  cnt1_reg, cnt2_reg;
    logic [15:0][CW-1:0] pair_reg;
    logic [CW-1:0]       seen_reg;

    // operands latched at pick
    logic [CW-1:0] maj1_reg, min1_reg, maj2_reg, min2_reg;
    logic [CW-1:0] m_reg, n_reg, s1_reg, s2_reg;

    logic [PW-1:0]   acc_reg, mcand_reg;
    logic [CW-1:0]   mplier_reg;
    logic [SW-1:0]   step_reg;
    logic [PW-1:0]   obs_reg, exp_reg, den_reg, r_reg;
    logic [2*CW-1:0] x_reg, y_reg;
    logic [tld_pkg::FRAC_BITS-1:0] q_reg;

    logic [2*CW+4:0] pk1, pk2;
    logic            gt;
    logic [2*CW-1:0] mn;
    logic [PW:0]     rs;
    logic [CW+16:0]  n_wide;
    logic            room;

    function automatic logic [2*CW+4:0] pick_two(input logic [3:0][CW-1:0] c);
        logic [1:0]    found;
        logic [1:0]    ia, ib;
        logic [CW-1:0] va, vb;
        found = '0;
        ia    = '0;
        ib    = '0;
        va    = '0;
        vb    = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (c[k] != '0)
            begin
                if (found == 2'd0)
                begin
                    ia = 2'(k);
                    va = c[k];
                end
                else if (found == 2'd1)
                begin
                    ib = 2'(k);
                    vb = c[k];
                end
                if (found != 2'd2)
                    found = found + 2'd1;
            end
        end
        return {found == 2'd2, ia, ib, va, vb};
    endfunction

    assign pk1  = pick_two(cnt1_reg);
    assign pk2  = pick_two(cnt2_reg);
    assign room = (seen_reg < CW'(MAX_HAPLOTYPES));
    assign gt   = (obs_reg > exp_reg);
    assign mn   = (x_reg < y_reg) ? x_reg : y_reg;
    assign rs   = {r_reg, 1'b0};

    assign st.ok        = pk1[2*CW+4] & pk2[2*CW+4];
    assign st.step_done = (step_reg == '0);
    assign st.den_zero  = (den_reg == '0);
    assign st.r_ge_den  = (r_reg >= den_reg);

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt1_reg <= '0;
            cnt2_reg <= '0;
            pair_reg <= '0;
            seen_reg <= '0;
        end
        else if (cmd.pick)
        begin
            cnt1_reg <= '0;
            cnt2_reg <= '0;
            pair_reg <= '0;
            seen_reg <= '0;
        end
        else if (cmd.count && room)
        begin
            seen_reg <= seen_reg + CW'(1);
            for (int k = 0; k < 4; k++)
            begin
                if (item.first_base == 3'(k))
                    cnt1_reg[k] <= cnt1_reg[k] + CW'(1);
                if (item.second_base == 3'(k))
                    cnt2_reg[k] <= cnt2_reg[k] + CW'(1);
            end
            for (int j = 0; j < 16; j++)
            begin
                if ({item.first_base, item.second_base} == {3'(j / 4), 3'(j % 4)})
                    pair_reg[j] <= pair_reg[j] + CW'(1);
            end
        end
    end

    // pick, multiply, divide
    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            maj1_reg <= pk1[2*CW-1:CW];
            min1_reg <= pk1[CW-1:0];
            maj2_reg <= pk2[2*CW-1:CW];
            min2_reg <= pk2[CW-1:0];
            m_reg    <= pair_reg[{pk1[2*CW+1:2*CW], pk2[2*CW+1:2*CW]}];
            n_reg    <= seen_reg;
            s1_reg   <= CW'(pk1[2*CW-1:CW] + pk1[CW-1:0]);
            s2_reg   <= CW'(pk2[2*CW-1:CW] + pk2[CW-1:0]);
        end

        if (cmd.mul_load)
        begin
            acc_reg  <= '0;
            step_reg <= SW'(CW - 1);
            case (cmd.mul_op)
                tld_pkg::OP_MS1: begin mcand_reg <= PW'(m_reg);    mplier_reg <= s1_reg; end
                tld_pkg::OP_OBS: begin mcand_reg <= acc_reg;       mplier_reg <= s2_reg; end
                tld_pkg::OP_C12: begin mcand_reg <= PW'(min1_reg); mplier_reg <= min2_reg; end
                tld_pkg::OP_EXP: begin mcand_reg <= acc_reg;       mplier_reg <= n_reg; end
                tld_pkg::OP_X:
                begin
                    mcand_reg  <= PW'(maj1_reg);
                    mplier_reg <= gt ? min2_reg : maj2_reg;
                end
                tld_pkg::OP_Y:
                begin
                    mcand_reg  <= PW'(min1_reg);
                    mplier_reg <= gt ? maj2_reg : min2_reg;
                end
                tld_pkg::OP_DEN: begin mcand_reg <= PW'(mn);       mplier_reg <= n_reg; end
                default:         begin mcand_reg <= '0;            mplier_reg <= '0; end
            endcase
        end
        else if (cmd.mul_step)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
            mplier_reg <= mplier_reg >> 1;
            step_reg   <= step_reg - SW'(1);
        end
        else if (cmd.div_load)
            step_reg <= SW'(tld_pkg::FRAC_BITS - 1);
        else if (cmd.div_step)
            step_reg <= step_reg - SW'(1);

        if (cmd.mul_save)
        begin
            case (cmd.mul_op)
                tld_pkg::OP_OBS: obs_reg <= acc_reg;
                tld_pkg::OP_EXP: exp_reg <= acc_reg;
                tld_pkg::OP_X:   x_reg   <= acc_reg[2*CW-1:0];
                tld_pkg::OP_Y:   y_reg   <= acc_reg[2*CW-1:0];
                tld_pkg::OP_DEN: den_reg <= acc_reg;
                default:         ;
            endcase
        end

        if (cmd.div_load)
        begin
            r_reg <= gt ? (obs_reg - exp_reg) : (exp_reg - obs_reg);
            q_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rs >= {1'b0, den_reg})
            begin
                r_reg <= PW'(rs - {1'b0, den_reg});
                q_reg <= {q_reg[tld_pkg::FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= rs[PW-1:0];
                q_reg <= {q_reg[tld_pkg::FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    // result beat
    assign n_wide = {{17{1'b0}}, n_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe <= 1'b0;
        else
            strobe <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result.haplotype_total <= n_wide[tld_pkg::TOTAL_W-1:0];
            case (cmd.res)
                tld_pkg::RES_SAT:
                begin
                    result.dprime         <= tld_pkg::DPRIME_ONE;
                    result.undefined_flag <= 1'b0;
                end
                tld_pkg::RES_QUOT:
                begin
                    result.dprime         <= {1'b0, q_reg};
                    result.undefined_flag <= 1'b0;
                end
                default:
                begin
                    result.dprime         <= '0;
                    result.undefined_flag <= 1'b1;
                end
            endcase
        end
    end

endmodule

/* hdl/two_locus_dprime.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_locus_dprime
// Normalized linkage disequilibrium D' between two loci from haplotype beats.
// ---------------------------------------------------------------------------
// One haplotype beat is taken per cycle while busy is low. The beat flagged
// last_haplotype starts the evaluation, during which busy stays high: seven
// CW-step shift-add multiplies, CW = $clog2(MAX_HAPLOTYPES+1), and a 16-step
// restoring divide; undefined or saturated results finish sooner. The result
// is shown for one cycle with strobe and cannot be held off; busy is already
// low in that cycle, and all counters are clear for the next locus pair.
module two_locus_dprime
#(
    parameter int MAX_HAPLOTYPES = 65536
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tld_pkg::in_t   item,
    output logic           strobe,
    output tld_pkg::out_t  result
);

    tld_pkg::cmd_t    cmd;
    tld_pkg::status_t st;

    tld_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (item.last_haplotype),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    tld_dpath
    #(
        .MAX_HAPLOTYPES (MAX_HAPLOTYPES)
    )
    u_dpath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .st     (st),
        .strobe (strobe),
        .result (result)
    );

`include "assert_macros.svh"

    `ASSERT_CLK(a_strobe_single, strobe |=> !strobe, "result strobe longer than one cycle")
    `ASSERT_NEVER(a_strobe_idle, strobe && busy, "result shown while still busy")
    `ASSERT_CLK(a_last_busy, (start && !busy && item.last_haplotype) |=> busy, "last beat did not start evaluation")

endmodule
